// ===== rtl/core/sre_pkg.sv =====
// ----------------------------------------------------------------------------
// sre_pkg
// Shared constants, 5x7 font and helper functions for the strip raster engine.
// ----------------------------------------------------------------------------
package sre_pkg;

  // Signed coordinate width. It covers glyph offsets, sums of two 12-bit
  // fields and line widths up to 4096.
  localparam int CW = 15;

  localparam int OpW = 3;
  localparam logic [OpW-1:0] OpRect  = 3'd0;
  localparam logic [OpW-1:0] OpDisc  = 3'd1;
  localparam logic [OpW-1:0] OpRing  = 3'd2;
  localparam logic [OpW-1:0] OpGlyph = 3'd3;
  localparam logic [OpW-1:0] OpClear = 3'd4;
  localparam logic [OpW-1:0] OpRead  = 3'd5;

  localparam logic RegStripTop    = 1'b0;
  localparam logic RegStripHeight = 1'b1;

  localparam logic [15:0] ColorBandA = 16'h08A4;
  localparam logic [15:0] ColorBandB = 16'h10E6;
  localparam int BandRows  = 36;
  localparam int BandShift = 16;
  localparam int BandRecip = ((1 << BandShift) + BandRows - 1) / BandRows;
  localparam int PctDiv    = 100;
  localparam int PctShift  = 19;
  localparam int PctRecip  = ((1 << PctShift) + PctDiv - 1) / PctDiv;
  localparam logic [14:0] CountMax = 15'h7FFF;

  localparam logic [6:0] SlotNone = 7'h7F;

  // Maps a character code to its font slot, SlotNone when unsupported.
  function automatic logic [6:0] glyph_slot(input logic [7:0] ch);
    logic [6:0] s;
    s = SlotNone;
    if (ch >= 8'h30 && ch <= 8'h39) s = 7'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h5A) s = 7'(ch - 8'h41 + 8'd10);
    else if (ch >= 8'h61 && ch <= 8'h7A) s = 7'(ch - 8'h61 + 8'd36);
    else if (ch == 8'h2E) s = 7'd62;
    else if (ch == 8'h2D || ch == 8'h5F) s = 7'd63;
    else if (ch == 8'h3A) s = 7'd64;
    return s;
  endfunction

  // Font columns, column 0 in the lowest byte; bit n of a column is row n.
  function automatic logic [39:0] font_glyph(input logic [6:0] slot);
    logic [39:0] g;
    case (slot)
      7'd0:  g = 40'h3E_45_49_51_3E;
      7'd1:  g = 40'h00_40_7F_42_00;
      7'd2:  g = 40'h46_49_51_61_42;
      7'd3:  g = 40'h31_4B_45_41_21;
      7'd4:  g = 40'h10_7F_12_14_18;
      7'd5:  g = 40'h39_45_45_45_27;
      7'd6:  g = 40'h30_49_49_4A_3C;
      7'd7:  g = 40'h03_05_09_71_01;
      7'd8:  g = 40'h36_49_49_49_36;
      7'd9:  g = 40'h1E_29_49_49_06;
      7'd10: g = 40'h7E_11_11_11_7E;
      7'd11: g = 40'h36_49_49_49_7F;
      7'd12: g = 40'h22_41_41_41_3E;
      7'd13: g = 40'h1C_22_41_41_7F;
      7'd14: g = 40'h41_49_49_49_7F;
      7'd15: g = 40'h01_09_09_09_7F;
      7'd16: g = 40'h7A_49_49_41_3E;
      7'd17: g = 40'h7F_08_08_08_7F;
      7'd18: g = 40'h00_41_7F_41_00;
      7'd19: g = 40'h01_3F_41_40_20;
      7'd20: g = 40'h41_22_14_08_7F;
      7'd21: g = 40'h40_40_40_40_7F;
      7'd22: g = 40'h7F_02_0C_02_7F;
      7'd23: g = 40'h7F_10_08_04_7F;
      7'd24: g = 40'h3E_41_41_41_3E;
      7'd25: g = 40'h06_09_09_09_7F;
      7'd26: g = 40'h5E_21_51_41_3E;
      7'd27: g = 40'h46_29_19_09_7F;
      7'd28: g = 40'h31_49_49_49_46;
      7'd29: g = 40'h01_01_7F_01_01;
      7'd30: g = 40'h3F_40_40_40_3F;
      7'd31: g = 40'h1F_20_40_20_1F;
      7'd32: g = 40'h3F_40_38_40_3F;
      7'd33: g = 40'h63_14_08_14_63;
      7'd34: g = 40'h07_08_70_08_07;
      7'd35: g = 40'h43_45_49_51_61;
      7'd36: g = 40'h78_54_54_54_20;
      7'd37: g = 40'h38_44_44_48_7F;
      7'd38: g = 40'h20_44_44_44_38;
      7'd39: g = 40'h7F_48_44_44_38;
      7'd40: g = 40'h18_54_54_54_38;
      7'd41: g = 40'h02_01_09_7E_08;
      7'd42: g = 40'h3E_52_52_52_0C;
      7'd43: g = 40'h78_04_04_08_7F;
      7'd44: g = 40'h00_40_7D_44_00;
      7'd45: g = 40'h00_3D_44_40_20;
      7'd46: g = 40'h00_44_28_10_7F;
      7'd47: g = 40'h00_40_7F_41_00;
      7'd48: g = 40'h78_04_18_04_7C;
      7'd49: g = 40'h78_04_04_08_7C;
      7'd50: g = 40'h38_44_44_44_38;
      7'd51: g = 40'h08_14_14_14_7C;
      7'd52: g = 40'h7C_18_14_14_08;
      7'd53: g = 40'h08_04_04_08_7C;
      7'd54: g = 40'h20_54_54_54_48;
      7'd55: g = 40'h20_40_44_3F_04;
      7'd56: g = 40'h7C_20_40_40_3C;
      7'd57: g = 40'h1C_20_40_20_1C;
      7'd58: g = 40'h3C_40_30_40_3C;
      7'd59: g = 40'h44_28_10_28_44;
      7'd60: g = 40'h3C_50_50_50_0C;
      7'd61: g = 40'h44_4C_54_64_44;
      7'd62: g = 40'h00_00_60_60_00;
      7'd63: g = 40'h08_08_08_08_08;
      7'd64: g = 40'h00_00_36_36_00;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/sre_strip_mem.sv =====
// ----------------------------------------------------------------------------
// sre_strip_mem
// Single write port, single read port pixel store with registered read data.
// ----------------------------------------------------------------------------
module sre_strip_mem #(
  parameter int DEPTH = 24576,
  parameter int AW    = 15
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/strip_raster_engine.sv =====
// ----------------------------------------------------------------------------
// strip_raster_engine
// RGB565 primitive rasterizer over a band of rows held in an on-chip store.
// ----------------------------------------------------------------------------
// Flow: a command passes its setup states, then scans its clipped bounding box
// row by row, with a row setup state ahead of each row. A glyph visits each
// of its 35 font dots and scales and fills a box for each set dot; a read
// passes S_READ and S_READW. The single pixel write port of the strip store
// sets the rate. One command is in flight at a time.
// Reset is asynchronous and active low; the strip store has no reset.
// ----------------------------------------------------------------------------
module strip_raster_engine
  import sre_pkg::*;
#(
  parameter int LINE_WIDTH = 1024,
  parameter int STRIP_ROWS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes.
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [9:0]   cfg_data_i,
  // Command stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: pos_x[11:0], pos_y[11:0], span_x[11:0], span_y[11:0],
  // radius_px[9:0], ring_thickness[9:0], glyph_code[7:0], scale_pct[11:0],
  // pixel_color[15:0].
  input  logic [103:0] s_axis_tdata,
  // tuser: operation[2:0].
  input  logic [2:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: read_color[15:0], pixels_written[14:0], one zero bit.
  output logic [31:0]  m_axis_tdata
);

  localparam int DEPTH = LINE_WIDTH * STRIP_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [CW-1:0] WS = CW'(LINE_WIDTH);
  localparam logic [6:0] RowsMax = 7'(STRIP_ROWS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BOX   = 4'd1;
  localparam logic [3:0] S_CSQ1  = 4'd2;
  localparam logic [3:0] S_CSQ2  = 4'd3;
  localparam logic [3:0] S_CSET  = 4'd4;
  localparam logic [3:0] S_ROW   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_GDOT  = 4'd7;
  localparam logic [3:0] S_GMUL  = 4'd8;
  localparam logic [3:0] S_GDIV  = 4'd9;
  localparam logic [3:0] S_GSET  = 4'd10;
  localparam logic [3:0] S_GADV  = 4'd11;
  localparam logic [3:0] S_READ  = 4'd12;
  localparam logic [3:0] S_READW = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  function automatic logic signed [CW-1:0] sx12(input logic [11:0] v);
    return {{(CW-12){v[11]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
                                                   input logic signed [CW-1:0] lo,
                                                   input logic signed [CW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  logic [3:0]  state_q, state_d;
  logic [9:0]  top_q;
  logic [4:0]  height_q;

  // Command fields held for the whole command.
  logic signed [CW-1:0] px_q, py_q;
  logic [9:0]  rad_q, thk_q;
  logic [11:0] scale_q;
  logic [15:0] color_q;
  logic        ring_q, circ_q, clr_q, glyph_q;
  logic [6:0]  slot_q;

  // Box being rasterized and scan position.
  logic signed [CW-1:0] bx_q, by_q, bw_q, bh_q;
  logic signed [CW-1:0] xlo_q, xhi_q, yhi_q, x_q, y_q;
  logic [19:0] outer_q, inner_q, dy2_q;
  logic [15:0] pen_q;

  // Glyph walk.
  logic [2:0]  gcol_q, grow_q;
  logic [1:0]  gk_q;
  logic [14:0] prod_q;
  logic [8:0]  gx0_q, gx1_q, gy0_q, gy1_q;

  logic [14:0] cnt_q;
  logic [15:0] rdc_q;
  logic        out_valid_q;
  logic [15:0] out_color_q;
  logic [14:0] out_cnt_q;

  logic [6:0]  live;
  logic signed [CW-1:0] top_s, bot_s;
  assign live  = ({2'b0, height_q} < RowsMax) ? {2'b0, height_q} : RowsMax;
  assign top_s = $signed({{(CW-10){1'b0}}, top_q});
  assign bot_s = top_s + $signed({{(CW-7){1'b0}}, live});

  // Shared squarer: radius, inner radius, row offset or column offset.
  logic signed [11:0] sq_in;
  logic signed [23:0] sq_full;
  logic [19:0] sq_out;
  always_comb begin
    case (state_q)
      S_CSQ1:  sq_in = $signed({2'b0, rad_q});
      S_CSQ2:  sq_in = $signed({2'b0, rad_q}) - $signed({2'b0, thk_q});
      S_ROW:   sq_in = 12'(y_q - py_q);
      default: sq_in = 12'(x_q - px_q);
    endcase
  end
  assign sq_full = sq_in * sq_in;
  assign sq_out  = sq_full[19:0];

  logic [20:0] d2_sum;
  logic        hit;
  assign d2_sum = {1'b0, sq_out} + {1'b0, dy2_q};
  assign hit    = !circ_q ||
                  ((d2_sum <= {1'b0, outer_q}) && (!ring_q || d2_sum >= {1'b0, inner_q}));

  // Strip store address of the current pixel or the read target.
  logic signed [CW-1:0] ay, ax;
  logic [AW-1:0] addr;
  assign ay   = (state_q == S_READ) ? py_q : y_q;
  assign ax   = (state_q == S_READ) ? px_q : x_q;
  assign addr = AW'(AW'(ay - top_s) * AW'(LINE_WIDTH) + AW'(ax));

  logic        mem_we, mem_re, rd_in;
  logic [15:0] mem_rdata;
  assign rd_in  = (px_q >= 0) && (px_q < WS) && (py_q >= top_s) && (py_q < bot_s);
  assign mem_we = (state_q == S_SCAN) && hit;
  assign mem_re = (state_q == S_READ) && rd_in;

  sre_strip_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i (pen_q),
    .re_i    (mem_re),
    .raddr_i (addr),
    .rdata_o (mem_rdata)
  );

  // Box clamp for rectangles, glyph dots and clear.
  logic signed [CW-1:0] cx0, cx1, cy0, cy1;
  assign cx0 = clampc(bx_q, '0, WS);
  assign cx1 = clampc(bx_q + bw_q, '0, WS);
  assign cy0 = clampc(by_q, top_s, bot_s);
  assign cy1 = clampc(by_q + bh_q, top_s, bot_s);

  // Circle bounding box, upper bounds exclusive.
  logic signed [CW-1:0] rs, ca0, ca1, cb0, cb1;
  assign rs  = $signed({{(CW-10){1'b0}}, rad_q});
  assign ca0 = (px_q - rs > 0) ? px_q - rs : '0;
  assign ca1 = (px_q + rs + CW'(1) < WS) ? px_q + rs + CW'(1) : WS;
  assign cb0 = (py_q - rs > top_s) ? py_q - rs : top_s;
  assign cb1 = (py_q + rs + CW'(1) < bot_s) ? py_q + rs + CW'(1) : bot_s;

  // Clear band of the row about to be scanned.
  logic [21:0] band_m;
  assign band_m = 22'(y_q[10:0]) * 22'(BandRecip);

  // Glyph span arithmetic.
  logic [39:0] font_w;
  logic [7:0]  font_col;
  logic        dot_set;
  logic [3:0]  gfac;
  logic [28:0] pct_m;
  logic [8:0]  pct_q;
  assign font_w   = font_glyph(slot_q);
  assign font_col = font_w[{gcol_q, 3'b000} +: 8];
  assign dot_set  = font_col[grow_q];
  always_comb begin
    case (gk_q)
      2'd0:    gfac = {1'b0, gcol_q};
      2'd1:    gfac = {1'b0, gcol_q} + 4'd1;
      2'd2:    gfac = {1'b0, grow_q};
      default: gfac = {1'b0, grow_q} + 4'd1;
    endcase
  end
  assign pct_m = 29'(prod_q) * 29'(PctRecip);
  assign pct_q = pct_m[PctShift +: 9];

  logic [8:0] gx1w, gy1w;
  assign gx1w = (gx1_q <= gx0_q) ? gx0_q + 9'd1 : gx1_q;
  assign gy1w = (gy1_q <= gy0_q) ? gy0_q + 9'd1 : gy1_q;

  logic last_x, last_y;
  assign last_x = (x_q + 1 >= xhi_q);
  assign last_y = (y_q + 1 >= yhi_q);

  logic in_fire, out_load;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            OpRect, OpClear: state_d = S_BOX;
            OpDisc, OpRing:  state_d = S_CSQ1;
            OpGlyph: begin
              if (glyph_slot(s_axis_tdata[75:68]) == SlotNone || s_axis_tdata[87:76] == '0)
                state_d = S_DONE;
              else
                state_d = S_GDOT;
            end
            OpRead:  state_d = S_READ;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_BOX:   state_d = (cx0 >= cx1 || cy0 >= cy1) ? (glyph_q ? S_GADV : S_DONE) : S_ROW;
      S_CSQ1:  state_d = S_CSQ2;
      S_CSQ2:  state_d = S_CSET;
      S_CSET:  state_d = (ca0 >= ca1 || cb0 >= cb1) ? S_DONE : S_ROW;
      S_ROW:   state_d = S_SCAN;
      S_SCAN: begin
        if (last_x) state_d = last_y ? (glyph_q ? S_GADV : S_DONE) : S_ROW;
      end
      S_GDOT:  state_d = dot_set ? S_GMUL : S_GADV;
      S_GMUL:  state_d = S_GDIV;
      S_GDIV:  state_d = (gk_q == 2'd3) ? S_GSET : S_GMUL;
      S_GSET:  state_d = S_BOX;
      S_GADV:  state_d = (grow_q == 3'd6 && gcol_q == 3'd4) ? S_DONE : S_GDOT;
      S_READ:  state_d = S_READW;
      S_READW: state_d = S_DONE;
      S_DONE:  state_d = out_load ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      height_q    <= 5'd24;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == RegStripTop) top_q <= cfg_data_i;
        else height_q <= cfg_data_i[4:0];
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        px_q    <= sx12(s_axis_tdata[11:0]);
        py_q    <= sx12(s_axis_tdata[23:12]);
        rad_q   <= s_axis_tdata[57:48];
        thk_q   <= s_axis_tdata[67:58];
        scale_q <= s_axis_tdata[87:76];
        color_q <= s_axis_tdata[103:88];
        pen_q   <= s_axis_tdata[103:88];
        slot_q  <= glyph_slot(s_axis_tdata[75:68]);
        circ_q  <= (s_axis_tuser == OpDisc) || (s_axis_tuser == OpRing);
        ring_q  <= (s_axis_tuser == OpRing);
        clr_q   <= (s_axis_tuser == OpClear);
        glyph_q <= (s_axis_tuser == OpGlyph);
        cnt_q   <= '0;
        rdc_q   <= '0;
        gcol_q  <= '0;
        grow_q  <= '0;
        gk_q    <= '0;
        dy2_q   <= '0;
        if (s_axis_tuser == OpClear) begin
          bx_q <= '0;
          bw_q <= WS;
          by_q <= $signed({{(CW-10){1'b0}}, top_q});
          bh_q <= $signed({{(CW-7){1'b0}}, live});
        end else begin
          bx_q <= sx12(s_axis_tdata[11:0]);
          by_q <= sx12(s_axis_tdata[23:12]);
          bw_q <= sx12(s_axis_tdata[35:24]);
          bh_q <= sx12(s_axis_tdata[47:36]);
        end
      end
      S_BOX: begin
        xlo_q <= cx0;
        x_q   <= cx0;
        xhi_q <= cx1;
        y_q   <= cy0;
        yhi_q <= cy1;
      end
      S_CSQ1: outer_q <= sq_out;
      S_CSQ2: inner_q <= sq_out;
      S_CSET: begin
        xlo_q <= ca0;
        x_q   <= ca0;
        xhi_q <= ca1;
        y_q   <= cb0;
        yhi_q <= cb1;
      end
      S_ROW: begin
        dy2_q <= circ_q ? sq_out : '0;
        if (clr_q) pen_q <= band_m[BandShift] ? ColorBandB : ColorBandA;
      end
      S_SCAN: begin
        if (hit && cnt_q != CountMax) cnt_q <= cnt_q + 15'd1;
        if (last_x) begin
          x_q <= xlo_q;
          y_q <= y_q + CW'(1);
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
      S_GMUL: prod_q <= 15'(gfac) * 15'(scale_q);
      S_GDIV: begin
        case (gk_q)
          2'd0:    gx0_q <= pct_q;
          2'd1:    gx1_q <= pct_q;
          2'd2:    gy0_q <= pct_q;
          default: gy1_q <= pct_q;
        endcase
        gk_q <= gk_q + 2'd1;
      end
      S_GSET: begin
        bx_q <= px_q + $signed({{(CW-9){1'b0}}, gx0_q});
        by_q <= py_q + $signed({{(CW-9){1'b0}}, gy0_q});
        bw_q <= $signed({{(CW-9){1'b0}}, gx1w - gx0_q});
        bh_q <= $signed({{(CW-9){1'b0}}, gy1w - gy0_q});
        pen_q <= color_q;
      end
      S_GADV: begin
        if (grow_q == 3'd6) begin
          grow_q <= '0;
          gcol_q <= gcol_q + 3'd1;
        end else begin
          grow_q <= grow_q + 3'd1;
        end
      end
      S_READW: rdc_q <= rd_in ? mem_rdata : '0;
      default: ;
    endcase
    if (out_load) begin
      out_color_q <= rdc_q;
      out_cnt_q   <= cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_color_q};

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strip raster engine: commands go in over the
// slave stream, each result is checked against a local pixel-accurate
// rasterizer that keeps its own copy of the strip and of the registers.
// ----------------------------------------------------------------------------
module tb_top;
  import sre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineW    = 1024;
  localparam int StripRws = 24;
  localparam int CycLimit = 6000000;

  // One drawing command as it travels on the input stream.
  typedef struct {
    logic [2:0]  op;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] span_x;
    logic [11:0] span_y;
    logic [9:0]  radius;
    logic [9:0]  thick;
    logic [7:0]  code;
    logic [11:0] scale;
    logic [15:0] color;
  } draw_cmd_t;

  // One result the block must return.
  typedef struct {
    logic [15:0] read_color;
    logic [14:0] pix_count;
  } draw_res_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic          cfg_index_i = 1'b0;
  logic [9:0]    cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;
  logic [2:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [31:0]   m_axis_tdata;

  strip_raster_engine uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // 5x7 font, five column bytes per character; bit n of a column is row n.
  localparam bit [7:0] FontCols [0:324] = '{
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36,
    8'h3E,8'h41,8'h41,8'h41,8'h22, 8'h7F,8'h41,8'h41,8'h22,8'h1C,
    8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
    8'h3E,8'h41,8'h49,8'h49,8'h7A, 8'h7F,8'h08,8'h08,8'h08,8'h7F,
    8'h00,8'h41,8'h7F,8'h41,8'h00, 8'h20,8'h40,8'h41,8'h3F,8'h01,
    8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h0C,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F,
    8'h3E,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h09,8'h09,8'h09,8'h06,
    8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01,
    8'h3F,8'h40,8'h40,8'h40,8'h3F, 8'h1F,8'h20,8'h40,8'h20,8'h1F,
    8'h3F,8'h40,8'h38,8'h40,8'h3F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h07,8'h08,8'h70,8'h08,8'h07, 8'h61,8'h51,8'h49,8'h45,8'h43,
    8'h20,8'h54,8'h54,8'h54,8'h78, 8'h7F,8'h48,8'h44,8'h44,8'h38,
    8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02,
    8'h0C,8'h52,8'h52,8'h52,8'h3E, 8'h7F,8'h08,8'h04,8'h04,8'h78,
    8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h7F,8'h10,8'h28,8'h44,8'h00, 8'h00,8'h41,8'h7F,8'h40,8'h00,
    8'h7C,8'h04,8'h18,8'h04,8'h78, 8'h7C,8'h08,8'h04,8'h04,8'h78,
    8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08,
    8'h48,8'h54,8'h54,8'h54,8'h20, 8'h04,8'h3F,8'h44,8'h40,8'h20,
    8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44,
    8'h0C,8'h50,8'h50,8'h50,8'h3C, 8'h44,8'h64,8'h54,8'h4C,8'h44,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h36,8'h36,8'h00,8'h00
  };

  // Local copy of the strip, the registers and the per-command write count.
  logic [15:0] strip_pix [0:LineW*StripRws-1];
  int          top_row = 0;
  int          height_reg = 24;
  int          pix_written;

  draw_cmd_t   cmd_q [$];
  draw_res_t   res_q [$];
  int          err_cnt = 0;
  int          res_cnt = 0;
  int          cycle_cnt = 0;
  int          snd_gap = 0;
  int          rcv_gap = 0;
  bit          no_idle = 1'b0;
  int          hold_token = 0;
  int          hold_seen = 0;

  function automatic int rows_live();
    return (height_reg < StripRws) ? height_reg : StripRws;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int sx12(logic [11:0] v);
    return int'($signed(v));
  endfunction

  task automatic put_pixel(int x, int y, logic [15:0] c);
    if (x < 0 || x >= LineW || y < top_row || y >= top_row + rows_live()) return;
    strip_pix[(y - top_row) * LineW + x] = c;
    pix_written++;
  endtask

  task automatic box_fill(int x, int y, int w, int h, logic [15:0] c);
    int x0, x1, y0, y1;
    x0 = clampi(x, 0, LineW);
    x1 = clampi(x + w, 0, LineW);
    y0 = clampi(y, top_row, top_row + rows_live());
    y1 = clampi(y + h, top_row, top_row + rows_live());
    for (int r = y0; r < y1; r++)
      for (int q = x0; q < x1; q++) put_pixel(q, r, c);
  endtask

  // Disc when ring is clear; otherwise the ring between inner and r*r.
  task automatic draw_circle(int cx, int cy, int r, longint inner, bit ring,
                             logic [15:0] c);
    int ya, yb, xa, xb;
    longint d;
    ya = (cy - r > top_row) ? cy - r : top_row;
    yb = (cy + r < top_row + rows_live() - 1) ? cy + r : top_row + rows_live() - 1;
    xa = (cx - r > 0) ? cx - r : 0;
    xb = (cx + r < LineW - 1) ? cx + r : LineW - 1;
    for (int y = ya; y <= yb; y++)
      for (int x = xa; x <= xb; x++) begin
        d = longint'(x - cx) * (x - cx) + longint'(y - cy) * (y - cy);
        if (d <= longint'(r) * r && (!ring || d >= inner)) put_pixel(x, y, c);
      end
  endtask

  function automatic int font_slot(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - 48;
    if (ch >= "A" && ch <= "Z") return int'(ch) - 65 + 10;
    if (ch >= "a" && ch <= "z") return int'(ch) - 97 + 36;
    if (ch == ".") return 62;
    if (ch == "-" || ch == "_") return 63;
    if (ch == ":") return 64;
    return -1;
  endfunction

  // Each set font dot becomes a box scaled by s percent, at least one pixel.
  task automatic glyph_draw(int x, int y, logic [7:0] ch, int s, logic [15:0] c);
    int slot, x0, x1, y0, y1;
    slot = font_slot(ch);
    if (slot < 0 || s <= 0) return;
    for (int col = 0; col < 5; col++)
      for (int row = 0; row < 7; row++) begin
        if (FontCols[slot*5 + col][row] == 1'b0) continue;
        x0 = (col * s) / 100;
        x1 = ((col + 1) * s) / 100;
        y0 = (row * s) / 100;
        y1 = ((row + 1) * s) / 100;
        if (x1 <= x0) x1 = x0 + 1;
        if (y1 <= y0) y1 = y0 + 1;
        box_fill(x + x0, y + y0, x1 - x0, y1 - y0, c);
      end
  endtask

  // Strip clear: 36-row bands alternate between the two background colors.
  task automatic band_clear();
    int ay;
    for (int r = 0; r < rows_live(); r++) begin
      ay = top_row + r;
      for (int x = 0; x < LineW; x++)
        put_pixel(x, ay, ((ay / BandRows) % 2 == 0) ? ColorBandA : ColorBandB);
    end
  endtask

  // Applies one command to the local strip and returns what it must report.
  task automatic rasterize(input draw_cmd_t c, output draw_res_t res);
    int px, py;
    longint ir;
    px = sx12(c.pos_x);
    py = sx12(c.pos_y);
    pix_written = 0;
    res.read_color = '0;
    case (c.op)
      OpRect:  box_fill(px, py, sx12(c.span_x), sx12(c.span_y), c.color);
      OpDisc:  draw_circle(px, py, int'(c.radius), 0, 1'b0, c.color);
      OpRing: begin
        ir = longint'(c.radius) - longint'(c.thick);
        draw_circle(px, py, int'(c.radius), ir * ir, 1'b1, c.color);
      end
      OpGlyph: glyph_draw(px, py, c.code, int'(c.scale), c.color);
      OpClear: band_clear();
      OpRead: begin
        if (px >= 0 && px < LineW && py >= top_row && py < top_row + rows_live())
          res.read_color = strip_pix[(py - top_row) * LineW + px];
      end
      default: ;
    endcase
    res.pix_count = (pix_written > 32767) ? CountMax : 15'(pix_written);
  endtask

  // Predicts at queueing time: registers only change while nothing is queued,
  // so the local state then matches the state at acceptance.
  task automatic issue(input draw_cmd_t c);
    draw_res_t r;
    rasterize(c, r);
    cmd_q.push_back(c);
    res_q.push_back(r);
  endtask

  function automatic draw_cmd_t blank_cmd(logic [2:0] op);
    draw_cmd_t c;
    c = '{op: op, pos_x: '0, pos_y: '0, span_x: '0, span_y: '0, radius: '0,
          thick: '0, code: '0, scale: '0, color: 16'($urandom)};
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // A random command. Most land on or near the strip with small sizes so the
  // run stays short; a few use whole-range field values.
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int sel, wide;
    sel = $urandom_range(0, 999);
    wide = ($urandom_range(0, 49) == 0);
    if (sel < 2) c = blank_cmd(OpClear);
    else if (sel < 12) c = blank_cmd(3'($urandom_range(6, 7)));
    else if (sel < 250) c = blank_cmd(OpRect);
    else if (sel < 450) c = blank_cmd(OpDisc);
    else if (sel < 650) c = blank_cmd(OpRing);
    else if (sel < 820) c = blank_cmd(OpGlyph);
    else c = blank_cmd(OpRead);
    c.pos_x  = wide ? 12'($urandom) : 12'($urandom_range(0, 1060) - 20);
    c.pos_y  = wide ? 12'($urandom)
                    : 12'(top_row + $urandom_range(0, rows_live() + 24) - 12);
    c.span_x = (wide && c.op == OpRect) ? 12'($urandom) : 12'($urandom_range(0, 44) - 4);
    c.span_y = (wide && c.op == OpRect) ? 12'($urandom) : 12'($urandom_range(0, 20) - 4);
    c.radius = ($urandom_range(0, 199) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
    c.thick  = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                           : 10'($urandom_range(0, c.radius + 3));
    c.code   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h2D, 8'h7A));
    c.scale  = ($urandom_range(0, 299) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
    if (c.op == OpRead && !wide) begin
      c.pos_x = 12'($urandom_range(0, LineW - 1));
      c.pos_y = 12'(top_row + $urandom_range(0, (rows_live() > 0) ? rows_live() - 1 : 0));
    end
    return c;
  endfunction

  // Registers are only touched while the engine is idle.
  task automatic write_reg(logic idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 10'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == RegStripTop) top_row = val & 10'h3FF;
    else height_reg = val & 5'h1F;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || res_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Input side: a transaction completes on valid and ready; the next command
  // is taken from the pending queue after a random gap, or at once while no_idle is set.
  always @(posedge clk_i) begin : drive_cmds
    draw_cmd_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (snd_gap > 0) begin
        snd_gap       <= snd_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        nxt = cmd_q.pop_front();
        s_axis_tdata  <= {nxt.color, nxt.scale, nxt.code, nxt.thick, nxt.radius,
                          nxt.span_y, nxt.span_x, nxt.pos_y, nxt.pos_x};
        s_axis_tuser  <= nxt.op;
        s_axis_tvalid <= 1'b1;
        snd_gap       <= no_idle ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: compares every result transaction with the oldest
  // prediction and paces tready, including one long hold-off on request.
  always @(posedge clk_i) begin : check_results
    draw_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_cnt++;
      if (res_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = res_q.pop_front();
        if (m_axis_tdata[15:0] !== want.read_color) begin
          $display("%0t: read_color expected %h actual %h",
                   $time, want.read_color, m_axis_tdata[15:0]);
          err_cnt++;
        end
        if (m_axis_tdata[30:16] !== want.pix_count) begin
          $display("%0t: pixels_written expected %0d actual %0d",
                   $time, want.pix_count, m_axis_tdata[30:16]);
          err_cnt++;
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen     <= hold_token;
      rcv_gap       <= 3000;
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap       <= rcv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) rcv_gap <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycLimit) begin
      $display("strip_raster_engine test failed");
      $finish;
    end
  end

  // Register settings visited one after another, extremes included.
  int phase_top [7] = '{0, 1023, 500, 35, 1, 340, 72};
  int phase_hgt [7] = '{24, 31, 1, 0, 25, 24, 13};

  initial begin
    draw_cmd_t c;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_reg(RegStripTop, phase_top[0]);
    write_reg(RegStripHeight, phase_hgt[0]);

    // Directed part. The clear comes first so every later read inside the strip
    // hits a pixel that has been written.
    issue(blank_cmd(OpClear));
    c = blank_cmd(OpRect);
    c.pos_x = 12'h800; c.pos_y = 12'h800; c.span_x = 12'h7FF; c.span_y = 12'h7FF;
    issue(c);
    c.pos_x = 12'd10; c.pos_y = 12'd5; c.span_x = 12'd0; c.span_y = 12'd4;
    issue(c);
    c.span_x = 12'hFFC; issue(c);
    c.pos_x = 12'd1020; c.pos_y = 12'hFFE; c.span_x = 12'd9; c.span_y = 12'd5;
    issue(c);
    c = blank_cmd(OpDisc); c.pos_x = 12'd40; c.pos_y = 12'd10; issue(c);
    c.radius = 10'h3FF; c.pos_x = 12'd512; issue(c);
    c = blank_cmd(OpRing); c.pos_x = 12'd100; c.pos_y = 12'd12;
    c.radius = 10'd6; c.thick = 10'd20; issue(c);
    c.thick = 10'd0; issue(c);
    c.thick = 10'd6; issue(c);
    c.thick = 10'h3FF; c.radius = 10'd9; issue(c);
    c = blank_cmd(OpGlyph); c.pos_x = 12'd200; c.pos_y = 12'd2;
    c.code = "A"; c.scale = 12'd100; issue(c);
    c.scale = 12'd0; issue(c);
    c.code = 8'hFF; c.scale = 12'd200; issue(c);
    c.code = "."; c.scale = 12'd1; issue(c);
    c.code = ":"; c.scale = 12'd250; issue(c);
    c.code = "_"; c.scale = 12'd130; issue(c);
    c.code = "8"; c.scale = 12'hFFF; c.pos_x = 12'hFF0; c.pos_y = 12'hFF8; issue(c);
    c = blank_cmd(OpRead); c.pos_x = 12'd40; c.pos_y = 12'd10; issue(c);
    c.pos_x = 12'd1023; c.pos_y = 12'd23; issue(c);
    c.pos_x = 12'hFFF; issue(c);
    c.pos_x = 12'd5; c.pos_y = 12'd24; issue(c);
    issue(blank_cmd(3'd6));
    issue(blank_cmd(3'd7));
    drain();

    // Random part, one batch per register setting, each opened by a clear.
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_reg(RegStripTop, phase_top[p]);
        write_reg(RegStripHeight, phase_hgt[p]);
      end
      no_idle = (p == 5);
      issue(blank_cmd(OpClear));
      for (int i = 0; i < 160; i++) begin
        if (p == 2 && i == 20) hold_token++;
        issue(random_cmd());
        // Keep the pending queue short so predictions stay near the stream.
        while (cmd_q.size() > 8) @(posedge clk_i);
      end
      // The sender pauses here until every result is back.
      drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered all drawing operations, unused codes and reads over %0d results",
             res_cnt);
    $display("across 7 strip settings with random stalls on both streams.");
    if (err_cnt == 0) begin
      $display("strip_raster_engine test passed");
    end else begin
      $display("strip_raster_engine test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sre_pkg.sv
rtl/core/sre_strip_mem.sv
rtl/core/strip_raster_engine.sv
tb/sv/tb_top.sv
